FILE: hw/rtl/hdsc_pkg.sv
// Shared types, constants and helper functions for the double SHA-256 header check.
// Used by every module under hw/rtl; depends on nothing.
package hdsc_pkg;

    typedef logic [31:0] t_word;

    localparam int NUM_HDR_WORDS = 19;
    localparam int NUM_ROUNDS    = 64;
    localparam int NUM_CELLS     = 3 * NUM_ROUNDS;
    localparam logic [4:0] HDR_IDX_LAST = 5'd18;
    localparam t_word PAD_ONE     = 32'h8000_0000;
    localparam t_word LEN_HEADER  = 32'd640;
    localparam t_word LEN_DIGEST  = 32'd256;
    localparam t_word MANT_MASK   = 32'h007f_ffff;
    localparam logic [7:0] EXP_MIN_FULL = 8'd3;
    localparam logic [7:0] EXP_MAX      = 8'd32;

    typedef struct packed {
        t_word             nonce;
        t_word [2:0]       tail;
        t_word [7:0]       hin;
    } t_side;

    typedef struct packed {
        logic              valid;
        t_word [7:0]       st;
        t_word [15:0]      w;
        t_side             side;
    } t_pipe;

    typedef enum logic [1:0] {
        JOIN_SECOND,
        JOIN_DIGEST,
        JOIN_FINAL
    } t_join_mode;

    localparam t_word [63:0] ROUND_K = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    localparam t_word [7:0] INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic t_word bswap(input t_word x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: hw/rtl/header_double_sha256_target_check_unit.sv
// Top level: header store, chain of 192 round cells with three join stages, target check.
// Depends on hdsc_pkg, hdsc_cell, hdsc_join.
//
// channel   | dir | tdata                                   | tuser
// s_axis    | in  | word_index, word_value, nonce           | kind
// m_axis    | out | nonce_out, hash_w0, hash_w1, hash_w2, hash_w3 | meets_target, target_invalid
//
// One beat accepted per cycle while the output is not stalled; a trial result passes through
// 192 round cells, 3 join stages, the target decode register and the output register.
// The whole chain advances together; a stalled output holds every stage.
// Reset clears all valid flags; header words are undefined until loaded.
module header_double_sha256_target_check_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // word_index[4:0], word_value[36:5], nonce[68:37]
    input  logic         s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [287:0] m_axis_tdata,  // nonce_out, hash_w0, hash_w1, hash_w2, hash_w3
    output logic [1:0]   m_axis_tuser   // meets_target, target_invalid
);
    import hdsc_pkg::*;

    t_word       r_hdr [NUM_HDR_WORDS];
    logic        s_adv;
    logic        s_acc;
    logic [4:0]  s_idx;
    t_pipe       s_entry;
    t_pipe       s_cell [NUM_CELLS];
    t_pipe       s_join [3];
    t_pipe       s_cin  [NUM_CELLS];

    logic         r_t_valid;
    t_word        r_t_nonce;
    logic [255:0] r_t_hash;
    logic [255:0] r_t_tgt;
    logic         r_t_inv;
    logic [255:0] n_t_hash;
    logic [255:0] n_t_tgt;
    logic         n_t_inv;
    logic [7:0]   s_ex;
    logic [23:0]  s_man;
    logic [4:0]   s_sh;

    logic         r_o_valid;
    logic [287:0] r_o_data;
    logic [1:0]   r_o_user;

    assign s_adv = !r_o_valid || m_axis_tready;
    assign s_axis_tready = s_adv;
    assign s_acc = s_axis_tvalid && s_adv;
    assign s_idx = s_axis_tdata[4:0];

    always_ff @(posedge i_clk) begin
        if (s_acc && !s_axis_tuser && s_idx <= HDR_IDX_LAST) begin
            r_hdr[s_idx] <= s_axis_tdata[36:5];
        end
    end

    always_comb begin
        s_entry.valid = s_acc && s_axis_tuser;
        s_entry.st    = INIT_H;
        for (int i = 0; i < 16; i++) begin
            s_entry.w[i] = bswap(r_hdr[i]);
        end
        s_entry.side.nonce   = s_axis_tdata[68:37];
        s_entry.side.tail[0] = r_hdr[16];
        s_entry.side.tail[1] = r_hdr[17];
        s_entry.side.tail[2] = r_hdr[18];
        s_entry.side.hin     = INIT_H;
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        if (g == 0) begin : g_in0
            assign s_cin[g] = s_entry;
        end else if (g == NUM_ROUNDS) begin : g_in1
            assign s_cin[g] = s_join[0];
        end else if (g == 2 * NUM_ROUNDS) begin : g_in2
            assign s_cin[g] = s_join[1];
        end else begin : g_inn
            assign s_cin[g] = s_cell[g - 1];
        end
        hdsc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_adv),
            .i_k     (ROUND_K[g % NUM_ROUNDS]),
            .i_pipe  (s_cin[g]),
            .o_pipe  (s_cell[g])
        );
    end

    hdsc_join u_join0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (s_adv), .i_mode (JOIN_SECOND),
        .i_pipe (s_cell[NUM_ROUNDS - 1]), .o_pipe (s_join[0])
    );
    hdsc_join u_join1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (s_adv), .i_mode (JOIN_DIGEST),
        .i_pipe (s_cell[2 * NUM_ROUNDS - 1]), .o_pipe (s_join[1])
    );
    hdsc_join u_join2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (s_adv), .i_mode (JOIN_FINAL),
        .i_pipe (s_cell[NUM_CELLS - 1]), .o_pipe (s_join[2])
    );

    always_comb begin
        n_t_hash = {bswap(s_join[2].st[7]), bswap(s_join[2].st[6]),
                    bswap(s_join[2].st[5]), bswap(s_join[2].st[4]),
                    bswap(s_join[2].st[3]), bswap(s_join[2].st[2]),
                    bswap(s_join[2].st[1]), bswap(s_join[2].st[0])};
        s_ex    = s_join[2].side.tail[2][31:24];
        s_man   = s_join[2].side.tail[2][23:0] & MANT_MASK[23:0];
        n_t_inv = (s_ex == 8'd0) || (s_ex > EXP_MAX);
        s_sh    = 5'd0;
        if (s_ex <= EXP_MIN_FULL) begin
            s_man = s_man >> {(EXP_MIN_FULL[1:0] - s_ex[1:0]), 3'b000};
        end else if (!n_t_inv) begin
            s_sh = 5'(s_ex - EXP_MIN_FULL);
        end
        n_t_tgt = {232'd0, s_man} << {s_sh, 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (s_adv) begin
            r_t_valid <= s_join[2].valid;
            r_o_valid <= r_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_t_nonce <= s_join[2].side.nonce;
            r_t_hash  <= n_t_hash;
            r_t_tgt   <= n_t_tgt;
            r_t_inv   <= n_t_inv;
            r_o_data  <= {r_t_hash[63:0], r_t_hash[127:64], r_t_hash[191:128],
                          r_t_hash[255:192], r_t_nonce};
            r_o_user  <= {r_t_inv, !r_t_inv && (r_t_hash <= r_t_tgt)};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

    a_inv_no_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("meets_target set with invalid target");
    a_load_no_trial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_cell[0].valid)
        else $error("load beat entered the hash chain");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !r_t_valid)
        else $error("valid survived reset");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_adv |=> $stable(r_t_valid) && $stable(s_join[2].valid))
        else $error("chain moved during stall");

endmodule

FILE: hw/rtl/hdsc_cell.sv
// One SHA-256 round cell: holds working state and the 16-word schedule window.
// Depends on hdsc_pkg.
module hdsc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  hdsc_pkg::t_word i_k,
    input  hdsc_pkg::t_pipe i_pipe,
    output hdsc_pkg::t_pipe o_pipe
);
    import hdsc_pkg::*;

    t_pipe n_pipe;
    t_pipe r_pipe;
    logic  r_valid;
    t_word s_t1, s_t2, s_s0, s_s1;

    always_comb begin
        n_pipe = i_pipe;
        s_t1 = i_pipe.st[7]
             + (rotr(i_pipe.st[4], 6) ^ rotr(i_pipe.st[4], 11) ^ rotr(i_pipe.st[4], 25))
             + ((i_pipe.st[4] & i_pipe.st[5]) ^ (~i_pipe.st[4] & i_pipe.st[6]))
             + i_k + i_pipe.w[0];
        s_t2 = (rotr(i_pipe.st[0], 2) ^ rotr(i_pipe.st[0], 13) ^ rotr(i_pipe.st[0], 22))
             + ((i_pipe.st[0] & i_pipe.st[1]) ^ (i_pipe.st[0] & i_pipe.st[2])
                ^ (i_pipe.st[1] & i_pipe.st[2]));
        n_pipe.st[7] = i_pipe.st[6];
        n_pipe.st[6] = i_pipe.st[5];
        n_pipe.st[5] = i_pipe.st[4];
        n_pipe.st[4] = i_pipe.st[3] + s_t1;
        n_pipe.st[3] = i_pipe.st[2];
        n_pipe.st[2] = i_pipe.st[1];
        n_pipe.st[1] = i_pipe.st[0];
        n_pipe.st[0] = s_t1 + s_t2;
        s_s0 = rotr(i_pipe.w[1], 7) ^ rotr(i_pipe.w[1], 18) ^ (i_pipe.w[1] >> 3);
        s_s1 = rotr(i_pipe.w[14], 17) ^ rotr(i_pipe.w[14], 19) ^ (i_pipe.w[14] >> 10);
        for (int i = 0; i < 15; i++) begin
            n_pipe.w[i] = i_pipe.w[i + 1];
        end
        n_pipe.w[15] = i_pipe.w[0] + s_s0 + i_pipe.w[9] + s_s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_pipe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    always_comb begin
        o_pipe       = r_pipe;
        o_pipe.valid = r_valid;
    end

endmodule

FILE: hw/rtl/hdsc_join.sv
// Feed-forward stage: adds the chaining value and, except in JOIN_FINAL, builds the next block.
// Depends on hdsc_pkg.
module hdsc_join (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  hdsc_pkg::t_join_mode i_mode,
    input  hdsc_pkg::t_pipe     i_pipe,
    output hdsc_pkg::t_pipe     o_pipe
);
    import hdsc_pkg::*;

    t_pipe       n_pipe;
    t_pipe       r_pipe;
    logic        r_valid;
    t_word [7:0] s_h;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            s_h[j] = i_pipe.side.hin[j] + i_pipe.st[j];
        end
        n_pipe = i_pipe;
        n_pipe.w = '0;
        unique case (i_mode)
            JOIN_SECOND: begin
                n_pipe.st       = s_h;
                n_pipe.side.hin = s_h;
                n_pipe.w[0]     = bswap(i_pipe.side.tail[0]);
                n_pipe.w[1]     = bswap(i_pipe.side.tail[1]);
                n_pipe.w[2]     = bswap(i_pipe.side.tail[2]);
                n_pipe.w[3]     = bswap(i_pipe.side.nonce);
                n_pipe.w[4]     = PAD_ONE;
                n_pipe.w[15]    = LEN_HEADER;
            end
            JOIN_DIGEST: begin
                n_pipe.st       = INIT_H;
                n_pipe.side.hin = INIT_H;
                for (int j = 0; j < 8; j++) begin
                    n_pipe.w[j] = s_h[j];
                end
                n_pipe.w[8]     = PAD_ONE;
                n_pipe.w[15]    = LEN_DIGEST;
            end
            JOIN_FINAL: begin
                n_pipe.st       = s_h;
            end
            default: begin
                n_pipe.st       = s_h;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_pipe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    always_comb begin
        o_pipe       = r_pipe;
        o_pipe.valid = r_valid;
    end

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for header_double_sha256_target_check_unit: loads header words,
// tries nonces and checks each result against an in-bench double SHA-256 and target predictor.
// Depends on the unit under test only.
`timescale 1ns / 1ps

module tb_top;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_TRIAL = 1'b1;
    localparam int   HDR_WORDS  = 19;
    localparam int   BITS_IDX   = 18;
    localparam int   DRAIN_CYC  = 250;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [31:0] nonce;
        logic        meets;
        logic        invalid;
        logic [63:0] hw [4];
    } t_trial_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [71:0]   s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [287:0]  m_axis_tdata;
    logic [1:0]    m_axis_tuser;

    logic [31:0]   hdr_words [HDR_WORDS];
    t_trial_result trial_results_q [$];
    int            mismatch_cnt = 0;
    int            burst_left = 0;
    int            trials_sent = 0;
    int            loads_sent = 0;
    int            hits_seen = 0;
    int            invalid_seen = 0;
    int            cyc = 0;

    header_double_sha256_target_check_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] byte_rev(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [255:0] sha_block(input logic [255:0] hin, input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        logic [255:0] hout;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3);
            s1 = ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10);
            w[i] = w[i - 16] + s0 + w[i - 7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = hin[255 - 32 * i -: 32];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hout[255 - 32 * i -: 32] = hin[255 - 32 * i -: 32] + v[i];
        return hout;
    endfunction

    function automatic t_trial_result hash_trial(input logic [31:0] nonce);
        logic [511:0]  b1, b2, b3;
        logic [255:0]  d1, d2, rev, tgt;
        logic [7:0]    ex;
        logic [31:0]   man;
        t_trial_result r;
        for (int i = 0; i < 16; i++) b1[511 - 32 * i -: 32] = byte_rev(hdr_words[i]);
        b2 = {byte_rev(hdr_words[16]), byte_rev(hdr_words[17]), byte_rev(hdr_words[18]),
              byte_rev(nonce), 32'h8000_0000, 320'd0, 32'd640};
        d1 = sha_block(sha_block(SHA_IV, b1), b2);
        b3 = {d1, 32'h8000_0000, 192'd0, 32'd256};
        d2 = sha_block(SHA_IV, b3);
        rev = {<<8{d2}};
        ex  = hdr_words[BITS_IDX][31:24];
        man = hdr_words[BITS_IDX] & 32'h007f_ffff;
        r.nonce = nonce;
        r.invalid = (ex == 8'd0) || (ex > 8'd32);
        if (ex != 8'd0 && ex <= 8'd3) begin
            man = man >> (8 * (3 - ex));
            ex = 8'd3;
        end
        tgt = 256'(man) << (8 * (int'(ex) - 3));
        r.meets = !r.invalid && (rev <= tgt);
        for (int i = 0; i < 4; i++) r.hw[i] = rev[255 - 64 * i -: 64];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    // drive one beat; bursts with random gaps between them
    task automatic send_beat(input logic kind, input logic [4:0] idx, input logic [31:0] val,
                             input logic [31:0] nonce);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, nonce, val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        if (kind == KIND_TRIAL) begin
            trial_results_q.push_back(hash_trial(nonce));
            trials_sent++;
        end else begin
            if (idx < HDR_WORDS) hdr_words[idx] = val;
            loads_sent++;
        end
    endtask

    task automatic load_word(input logic [4:0] idx, input logic [31:0] val);
        send_beat(KIND_LOAD, idx, val, $urandom());
    endtask

    task automatic try_nonce(input logic [31:0] nonce);
        send_beat(KIND_TRIAL, 5'($urandom()), $urandom(), nonce);
    endtask

    task automatic wait_results;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (trial_results_q.size() != 0);
    endtask

    function automatic logic [31:0] random_bits_word;
        logic [7:0] ex;
        case ($urandom_range(0, 9))
            0:       ex = 8'd0;
            1:       ex = 8'($urandom_range(1, 3));
            2:       ex = 8'($urandom_range(33, 255));
            3:       ex = 8'($urandom_range(4, 31));
            default: ex = 8'd32;
        endcase
        return {ex, 24'($urandom())};
    endfunction

    task automatic test_header_load;
        load_word(5'd0, 32'h0000_0000);
        load_word(5'd1, 32'hffff_ffff);
        for (int i = 2; i < HDR_WORDS - 1; i++) load_word(5'(i), $urandom());
        load_word(5'(BITS_IDX), {8'd32, 24'hff_ffff});
        try_nonce(32'h0000_0000);
        try_nonce(32'hffff_ffff);
    endtask

    task automatic test_ignored_index;
        load_word(5'd19, 32'hffff_ffff);
        load_word(5'd31, 32'h0000_0000);
        try_nonce($urandom());
    endtask

    task automatic test_target_forms;
        logic [31:0] forms [8] = '{
            {8'd0, 24'h7f_ffff}, {8'd1, 24'hff_ffff}, {8'd2, 24'h12_3456},
            {8'd3, 24'h80_0001}, {8'd32, 24'h80_0000}, {8'd33, 24'h7f_ffff},
            {8'd255, 24'hff_ffff}, {8'd29, 24'h00_ffff}
        };
        foreach (forms[i]) begin
            load_word(5'(BITS_IDX), forms[i]);
            try_nonce($urandom());
        end
    endtask

    task automatic test_random_traffic(input int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) wait_results();
            sel = $urandom_range(0, 99);
            if (sel < 70) try_nonce($urandom());
            else if (sel < 80) load_word(5'(BITS_IDX), random_bits_word());
            else if (sel < 95) load_word(5'($urandom_range(0, HDR_WORDS - 2)), $urandom());
            else load_word(5'($urandom_range(HDR_WORDS, 31)), $urandom());
        end
    endtask

    // receiver stall pattern rotates through four modes, from always ready to periodic stalls
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        case ((cyc / 300) % 4)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom());
            2:       m_axis_tready <= (cyc % 8) != 0;
            default: m_axis_tready <= (cyc % 64) >= 20;
        endcase
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (trial_results_q.size() == 0) begin
                report_mismatch("unexpected beat", 64'(m_axis_tdata[31:0]), 64'd0);
            end else begin
                t_trial_result want;
                want = trial_results_q.pop_front();
                if (m_axis_tdata[31:0] !== want.nonce)
                    report_mismatch("nonce_out", 64'(m_axis_tdata[31:0]), 64'(want.nonce));
                if (m_axis_tuser[0] !== want.meets)
                    report_mismatch("meets_target", 64'(m_axis_tuser[0]), 64'(want.meets));
                if (m_axis_tuser[1] !== want.invalid)
                    report_mismatch("target_invalid", 64'(m_axis_tuser[1]), 64'(want.invalid));
                for (int i = 0; i < 4; i++)
                    if (m_axis_tdata[32 + 64 * i +: 64] !== want.hw[i])
                        report_mismatch($sformatf("hash_w%0d", i),
                                        m_axis_tdata[32 + 64 * i +: 64], want.hw[i]);
                if (want.meets) hits_seen++;
                if (want.invalid) invalid_seen++;
            end
        end
    end

    initial begin
        for (int i = 0; i < HDR_WORDS; i++) hdr_words[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_load();
        test_ignored_index();
        test_target_forms();
        test_random_traffic(1600);
        wait_results();
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("covered %0d loads and %0d trials: %0d met target, %0d invalid targets",
                 loads_sent, trials_sent, hits_seen, invalid_seen);
        if (mismatch_cnt == 0 && trial_results_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt,
                     trial_results_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", trial_results_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
